FILE: design/mst_pkg.sv
// Package for the multi-channel software timer table.
// Holds field widths, request and slot status codes, the slot record type and
// the command and status structs shared by the controller and the datapath.
package mst_pkg;

	localparam int NUM_SLOTS_DEF = 18;

	localparam int REQ_W = 3;
	localparam int HANDLE_W = 5;
	localparam int PERIOD_W = 32;
	localparam int FIRED_W = 18;

	localparam logic [REQ_W-1:0] REQ_TICK = 3'd0;
	localparam logic [REQ_W-1:0] REQ_CREATE = 3'd1;
	localparam logic [REQ_W-1:0] REQ_DELETE = 3'd2;
	localparam logic [REQ_W-1:0] REQ_ENABLE = 3'd3;
	localparam logic [REQ_W-1:0] REQ_DISABLE = 3'd4;
	localparam logic [REQ_W-1:0] REQ_CHPER = 3'd5;

	localparam logic [1:0] ST_FREE = 2'd0;
	localparam logic [1:0] ST_STOP = 2'd1;
	localparam logic [1:0] ST_RUN = 2'd2;

	typedef struct packed {
		logic [PERIOD_W-1:0] reload;
		logic [PERIOD_W-1:0] current;
		logic [1:0]          status;
		logic                rpt;
	} slot_rec_t;

	localparam int REC_W = $bits(slot_rec_t);

	typedef struct packed {
		logic load;
		logic sweep_rd;
		logic sweep_wr;
		logic single_rd;
		logic single_wr;
		logic finish;
	} dp_cmd_t;

	typedef struct packed {
		logic op_sweep;
		logic op_single;
		logic sweep_done;
		logic out_free;
	} dp_sts_t;

endpackage

FILE: design/mst_req_if.sv
// Request channel of the software timer table.
// Depends on mst_pkg for the field widths.
interface mst_req_if;
	logic                          valid;
	logic                          ready;
	logic [mst_pkg::REQ_W-1:0]     req_type;
	logic [mst_pkg::HANDLE_W-1:0]  timer_handle;
	logic [mst_pkg::PERIOD_W-1:0]  period;
	logic                          repeat_req;
	logic                          start_running;

	modport source (output valid, req_type, timer_handle, period, repeat_req, start_running,
		input ready);
	modport sink (input valid, req_type, timer_handle, period, repeat_req, start_running,
		output ready);
endinterface

FILE: design/mst_rsp_if.sv
// Response channel of the software timer table.
// Depends on mst_pkg for the field widths.
interface mst_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [mst_pkg::HANDLE_W-1:0]  new_handle;
	logic [mst_pkg::FIRED_W-1:0]   fired_mask;
	logic                          accepted;

	modport source (output valid, new_handle, fired_mask, accepted, input ready);
	modport sink (input valid, new_handle, fired_mask, accepted, output ready);
endinterface

FILE: design/mst_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module mst_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [AW-1:0]            waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [AW-1:0]            raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: design/mst_ctrl.sv
// Controller state machine of the software timer table.
// Depends on mst_pkg for the command and status structs.
module mst_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_ready,
	input  mst_pkg::dp_sts_t sts,
	output mst_pkg::dp_cmd_t cmd
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_DISPATCH = 3'd1;
	localparam logic [2:0] S_SWEEP = 3'd2;
	localparam logic [2:0] S_SINGLE = 3'd3;
	localparam logic [2:0] S_DONE = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_nxt;

	assign req_ready = (state_q == S_IDLE);

	always_comb begin
		cmd = '0;
		state_nxt = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.load = 1'b1;
					state_nxt = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				if (sts.op_sweep) begin
					cmd.sweep_rd = 1'b1;
					state_nxt = S_SWEEP;
				end else if (sts.op_single) begin
					cmd.single_rd = 1'b1;
					state_nxt = S_SINGLE;
				end else begin
					state_nxt = S_DONE;
				end
			end
			S_SWEEP: begin
				cmd.sweep_wr = 1'b1;
				if (sts.sweep_done) begin
					state_nxt = S_DONE;
				end else begin
					cmd.sweep_rd = 1'b1;
				end
			end
			S_SINGLE: begin
				cmd.single_wr = 1'b1;
				state_nxt = S_DONE;
			end
			S_DONE: begin
				if (sts.out_free) begin
					cmd.finish = 1'b1;
					state_nxt = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

FILE: design/mst_datapath.sv
// Datapath of the software timer table: slot record RAM, valid bits, request
// and sweep registers, slot update logic and the result register.
// Depends on mst_pkg and mst_ram.
module mst_datapath #(
	parameter int NUM_SLOTS = mst_pkg::NUM_SLOTS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  mst_pkg::dp_cmd_t              cmd,
	output mst_pkg::dp_sts_t              sts,
	input  logic [mst_pkg::REQ_W-1:0]     req_type,
	input  logic [mst_pkg::HANDLE_W-1:0]  timer_handle,
	input  logic [mst_pkg::PERIOD_W-1:0]  period,
	input  logic                          repeat_req,
	input  logic                          start_running,
	input  logic                          rsp_ready,
	output logic                          rsp_valid,
	output logic [mst_pkg::HANDLE_W-1:0]  new_handle,
	output logic [mst_pkg::FIRED_W-1:0]   fired_mask,
	output logic                          accepted
);

	localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int CNT_W = $clog2(NUM_SLOTS + 1);
	localparam int HCMP_W = CNT_W + mst_pkg::HANDLE_W;

	logic [mst_pkg::REQ_W-1:0]    req_type_q;
	logic [mst_pkg::PERIOD_W-1:0] period_q;
	logic                         rpt_q;
	logic                         run_q;
	logic                         slot_ok_q;
	logic [IDX_W-1:0]             slot_idx_q;
	logic [CNT_W-1:0]             rd_cnt_q;
	logic                         found_q;
	logic [NUM_SLOTS-1:0]         valid_q;
	logic                         vld_s1;
	logic                         rvld_s1;
	logic [IDX_W-1:0]             idx_s1;
	logic [mst_pkg::HANDLE_W-1:0] new_handle_q;
	logic [mst_pkg::FIRED_W-1:0]  fired_q;
	logic                         acc_q;
	logic                         out_valid_q;
	logic [mst_pkg::HANDLE_W-1:0] out_handle_q;
	logic [mst_pkg::FIRED_W-1:0]  out_fired_q;
	logic                         out_acc_q;

	logic                         rd_issue;
	logic [IDX_W-1:0]             rd_addr;
	logic [mst_pkg::REC_W-1:0]    rdata;
	mst_pkg::slot_rec_t           rec;
	mst_pkg::slot_rec_t           wr_rec;
	logic                         wr_en;
	logic                         set_vld;
	logic                         clr_vld;
	logic                         hit;
	logic                         found_now;
	logic                         fire;
	logic                         slot_ok_in;

	assign slot_ok_in = (timer_handle != '0)
		&& (HCMP_W'(timer_handle) <= HCMP_W'(NUM_SLOTS));

	assign rd_issue = cmd.single_rd
		|| (cmd.sweep_rd && (rd_cnt_q != CNT_W'(NUM_SLOTS)) && !found_q);
	assign rd_addr = cmd.single_rd ? slot_idx_q : rd_cnt_q[IDX_W-1:0];
	assign rec = rvld_s1 ? mst_pkg::slot_rec_t'(rdata) : '0;

	assign sts.op_sweep = (req_type_q == mst_pkg::REQ_TICK)
		|| (req_type_q == mst_pkg::REQ_CREATE);
	assign sts.op_single = slot_ok_q && ((req_type_q == mst_pkg::REQ_DELETE)
		|| (req_type_q == mst_pkg::REQ_ENABLE) || (req_type_q == mst_pkg::REQ_DISABLE)
		|| (req_type_q == mst_pkg::REQ_CHPER));
	assign sts.sweep_done = found_q || ((rd_cnt_q == CNT_W'(NUM_SLOTS)) && !vld_s1);
	assign sts.out_free = !out_valid_q || rsp_ready;

	always_comb begin
		wr_en = 1'b0;
		wr_rec = rec;
		set_vld = 1'b0;
		clr_vld = 1'b0;
		hit = 1'b0;
		found_now = 1'b0;
		fire = 1'b0;
		if (cmd.sweep_wr && vld_s1) begin
			if (req_type_q == mst_pkg::REQ_TICK) begin
				if (rec.status == mst_pkg::ST_RUN) begin
					wr_en = 1'b1;
					if (rec.current == '0) begin
						wr_rec.current = rec.reload;
						fire = 1'b1;
						if (!rec.rpt) begin
							wr_rec.status = mst_pkg::ST_STOP;
						end
					end else begin
						wr_rec.current = rec.current - 1'b1;
					end
				end
			end else if (!found_q && (rec.status == mst_pkg::ST_FREE)) begin
				wr_en = 1'b1;
				set_vld = 1'b1;
				found_now = 1'b1;
				hit = 1'b1;
				wr_rec.reload = period_q;
				wr_rec.current = period_q;
				wr_rec.status = run_q ? mst_pkg::ST_RUN : mst_pkg::ST_STOP;
				wr_rec.rpt = rpt_q;
			end
		end
		if (cmd.single_wr) begin
			case (req_type_q)
				mst_pkg::REQ_DELETE: begin
					clr_vld = 1'b1;
					hit = 1'b1;
				end
				mst_pkg::REQ_ENABLE: begin
					if (rec.status != mst_pkg::ST_FREE) begin
						wr_en = 1'b1;
						hit = 1'b1;
						wr_rec.current = rec.reload;
						wr_rec.status = mst_pkg::ST_RUN;
					end
				end
				mst_pkg::REQ_DISABLE: begin
					if (rec.status != mst_pkg::ST_FREE) begin
						wr_en = 1'b1;
						hit = 1'b1;
						wr_rec.status = mst_pkg::ST_STOP;
					end
				end
				mst_pkg::REQ_CHPER: begin
					wr_en = 1'b1;
					set_vld = 1'b1;
					hit = 1'b1;
					wr_rec.reload = period_q;
					wr_rec.current = period_q;
				end
				default: begin
				end
			endcase
		end
	end

	mst_ram #(
		.WIDTH(mst_pkg::REC_W),
		.DEPTH(NUM_SLOTS)
	) u_slot_ram (
		.clk  (clk),
		.we   (wr_en),
		.waddr(idx_s1),
		.wdata(wr_rec),
		.re   (rd_issue),
		.raddr(rd_addr),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_cnt_q <= '0;
			found_q <= 1'b0;
			valid_q <= '0;
			vld_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				rd_cnt_q <= '0;
				found_q <= 1'b0;
			end else begin
				if (rd_issue && !cmd.single_rd) begin
					rd_cnt_q <= rd_cnt_q + 1'b1;
				end
				if (found_now) begin
					found_q <= 1'b1;
				end
			end
			if (set_vld) begin
				valid_q[idx_s1] <= 1'b1;
			end else if (clr_vld) begin
				valid_q[idx_s1] <= 1'b0;
			end
			vld_s1 <= rd_issue;
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_type_q <= req_type;
			period_q <= period;
			rpt_q <= repeat_req;
			run_q <= start_running;
			slot_ok_q <= slot_ok_in;
			slot_idx_q <= IDX_W'(HCMP_W'(timer_handle) - HCMP_W'(1));
			new_handle_q <= '0;
			fired_q <= '0;
			acc_q <= (req_type == mst_pkg::REQ_TICK);
		end else begin
			if (fire) begin
				fired_q <= fired_q | (mst_pkg::FIRED_W'(1) << idx_s1);
			end
			if (found_now) begin
				new_handle_q <= mst_pkg::HANDLE_W'(CNT_W'(idx_s1) + CNT_W'(1));
			end
			if (hit) begin
				acc_q <= 1'b1;
			end
		end
		idx_s1 <= rd_addr;
		rvld_s1 <= valid_q[rd_addr];
		if (cmd.finish) begin
			out_handle_q <= new_handle_q;
			out_fired_q <= fired_q;
			out_acc_q <= acc_q;
		end
	end

	assign rsp_valid = out_valid_q;
	assign new_handle = out_handle_q;
	assign fired_mask = out_fired_q;
	assign accepted = out_acc_q;

endmodule

FILE: design/multi_channel_soft_timer.sv
// Top level of the multi-channel software timer table.
// Depends on mst_pkg, mst_req_if, mst_rsp_if, mst_ctrl and mst_datapath.
//
//   Port   Direction  Beat contents
//   req    in         req_type, timer_handle, period, repeat_req, start_running
//   rsp    out        new_handle, fired_mask, accepted
//
// A tick visits every slot, one per cycle, through the single read port of the slot RAM.
// A create stops after the first free slot. Delete, enable, disable and change period touch
// only the addressed slot; a bad handle or an unused request code skips the slot RAM.
// Reset clears the valid bits of the slot RAM at once, so a slot never written reads
// as free with zero counts; there is no clearing pass.
// A new request is taken while the previous result still waits in the output register;
// the next result then holds in its last cycle until that register empties.
module multi_channel_soft_timer #(
	parameter int NUM_SLOTS = mst_pkg::NUM_SLOTS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	mst_req_if.sink     req,
	mst_rsp_if.source   rsp
);

	mst_pkg::dp_cmd_t cmd;
	mst_pkg::dp_sts_t sts;

	mst_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req.valid),
		.req_ready(req.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	mst_datapath #(
		.NUM_SLOTS(NUM_SLOTS)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.req_type     (req.req_type),
		.timer_handle (req.timer_handle),
		.period       (req.period),
		.repeat_req   (req.repeat_req),
		.start_running(req.start_running),
		.rsp_ready    (rsp.ready),
		.rsp_valid    (rsp.valid),
		.new_handle   (rsp.new_handle),
		.fired_mask   (rsp.fired_mask),
		.accepted     (rsp.accepted)
	);

endmodule
